>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL. Each one is clocked on clk and is
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ssd_pkg.sv
package ssd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN         = 3'd0,
        CFG_DEADBAND     = 3'd1,
        CFG_MIN_POSITION = 3'd2,
        CFG_MAX_POSITION = 3'd3,
        CFG_THRESHOLD    = 3'd4,
        CFG_DIVIDER_SLOW = 3'd5,
        CFG_DIVIDER_FAST = 3'd6,
        CFG_PWM_WRAP     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [23:0] gain;
        logic [11:0] deadband;
        logic [11:0] min_position;
        logic [11:0] max_position;
        logic [14:0] threshold;
        logic [11:0] divider_slow;
        logic [11:0] divider_fast;
        logic [15:0] pwm_wrap;
    } cfg_t;

    localparam logic [23:0] GAIN_RESET         = 24'd5033;
    localparam logic [11:0] DEADBAND_RESET     = 12'd50;
    localparam logic [11:0] MIN_POSITION_RESET = 12'd800;
    localparam logic [11:0] MAX_POSITION_RESET = 12'd2200;
    localparam logic [14:0] THRESHOLD_RESET    = 15'd2621;
    localparam logic [11:0] DIVIDER_SLOW_RESET = 12'd240;
    localparam logic [11:0] DIVIDER_FAST_RESET = 12'd120;
    localparam logic [15:0] PWM_WRAP_RESET     = 16'd5000;

    localparam logic signed [15:0] DRIVE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] DRIVE_MIN = -16'sh8000;

endpackage

>>> hw/rtl/ssd_in_if.sv
interface ssd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] steer_command;
    logic        [11:0] sensor_position;

    modport source (output valid, output steer_command, output sensor_position, input ready);
    modport sink (input valid, input steer_command, input sensor_position, output ready);
endinterface

>>> hw/rtl/ssd_out_if.sv
interface ssd_out_if;
    logic               valid;
    logic               ready;
    logic               direction;
    logic        [11:0] clock_divider;
    logic        [14:0] pwm_level;
    logic signed [15:0] drive;

    modport source (output valid, output direction, output clock_divider,
                    output pwm_level, output drive, input ready);
    modport sink (input valid, input direction, input clock_divider,
                  input pwm_level, input drive, output ready);
endinterface

>>> hw/rtl/steer_servo_drive_unit.sv
// Steering servo drive: proportional position control with a deadband.
// The req channel carries a signed Q1.15 steering command and a 12-bit
// position sample; the rsp channel returns one result per transfer:
// direction, PWM clock divider, PWM compare level and the Q1.15 drive.
// Registers are written through cfg_we/cfg_index/cfg_data, one per cycle;
// the user must write only while no item is in flight; nothing enforces it.
// The datapath is a four-stage pipeline: setpoint multiply, gain multiply,
// scaling and saturation, divider multiply into the output register.
// A req item passes the setpoint, gain, scaling and output registers in
// turn before rsp.valid rises. A new item is taken every cycle unless the
// output stalls; the throughput is one item per cycle while it does not,
// because each stage holds one item and all stages move together.
// When the receiver holds rsp.ready low with a result waiting, the whole
// pipeline freezes and req.ready drops; nothing is lost or repeated, and
// the pipeline resumes in the cycle that rsp.ready returns.
// Reset empties the pipeline and loads every config register with its default
// value; there is no clearing pass, and req.ready is high right after.
module steer_servo_drive_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    ssd_in_if.sink                         req,
    ssd_out_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

    ssd_pkg::cfg_t cfg;

    ssd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // valid_reg[0..2] are stages one to three, valid_reg[3] is the output.
    logic [3:0] valid_reg;
    logic       advance;

    assign advance   = !valid_reg[3] || rsp.ready;
    assign req.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[2:0], req.valid};
        end
    end

    // Stage 1: setpoint = ((cmd + 32768) * (hi - lo) + lo * 65536) / 65536.
    logic        [15:0] s1_ucmd;
    logic signed [12:0] s1_span;
    logic signed [29:0] s1_prod;
    logic signed [30:0] s1_num;
    logic        [11:0] setpoint_next;
    logic        [11:0] setpoint_reg;
    logic        [11:0] pos1_reg;

    assign s1_ucmd = {~req.steer_command[15], req.steer_command[14:0]};
    assign s1_span = $signed({1'b0, cfg.max_position}) - $signed({1'b0, cfg.min_position});
    assign s1_prod = $signed({1'b0, s1_ucmd}) * s1_span;
    assign s1_num  = {s1_prod[29], s1_prod} + $signed({3'b000, cfg.min_position, 16'h0000});
    // The numerator never goes negative and stays below 2**28.
    assign setpoint_next = s1_num[27:16];

    // Stage 2: error, deadband and gain product.
    logic signed [12:0] s2_err;
    logic        [12:0] s2_mag;
    logic signed [37:0] s2_full;
    logic signed [36:0] prod_next;
    logic signed [36:0] prod_reg;
    logic               cut_next;
    logic               cut_reg;

    assign s2_err    = $signed({1'b0, pos1_reg}) - $signed({1'b0, setpoint_reg});
    assign s2_mag    = s2_err[12] ? 13'(-s2_err) : 13'(s2_err);
    assign s2_full   = $signed({1'b0, cfg.gain}) * s2_err;
    assign prod_next = (s2_mag > {1'b0, cfg.deadband}) ? s2_full[36:0] : '0;
    assign cut_next  = (pos1_reg > cfg.max_position) || (pos1_reg < cfg.min_position);

    // Stage 3: divide by 512 toward zero, saturate, end-stop cutoff.
    logic signed [36:0] s3_biased;
    logic signed [27:0] s3_quot;
    logic signed [15:0] s3_sat;
    logic signed [15:0] drive3_next;
    logic signed [15:0] drive3_reg;
    logic               dir3_next;
    logic               dir3_reg;
    logic        [15:0] mag_next;
    logic        [15:0] mag_reg;

    assign s3_biased = prod_reg[36] ? prod_reg + 37'sd511 : prod_reg;
    assign s3_quot   = s3_biased[36:9];

    always_comb
    begin
        if (s3_quot > 28'sd32767)
        begin
            s3_sat = ssd_pkg::DRIVE_MAX;
        end
        else if (s3_quot < -28'sd32768)
        begin
            s3_sat = ssd_pkg::DRIVE_MIN;
        end
        else
        begin
            s3_sat = s3_quot[15:0];
        end
    end

    assign dir3_next   = s3_sat[15];
    assign drive3_next = cut_reg ? '0 : s3_sat;
    // The magnitude of -32768 is 32768, which still fits 16 unsigned bits.
    assign mag_next    = drive3_next[15] ? 16'(-drive3_next) : 16'(drive3_next);

    // Stage 4: divider interpolation and level into the output register.
    logic signed [12:0] s4_diff;
    logic signed [29:0] s4_prod;
    logic signed [30:0] s4_num;
    logic        [11:0] div_next;
    logic        [14:0] level_next;
    logic        [11:0] div_reg;
    logic        [14:0] level_reg;
    logic signed [15:0] drive4_reg;
    logic               dir4_reg;

    assign s4_diff    = $signed({1'b0, cfg.divider_slow}) - $signed({1'b0, cfg.divider_fast});
    assign s4_prod    = s4_diff * $signed({1'b0, mag_reg});
    assign s4_num     = $signed({4'b0000, cfg.divider_slow, 15'h0000})
                        - {s4_prod[29], s4_prod};
    assign div_next   = s4_num[26:15];
    assign level_next = ({1'b0, mag_reg} > {2'b00, cfg.threshold}) ? cfg.pwm_wrap[15:1] : '0;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            setpoint_reg <= setpoint_next;
            pos1_reg     <= req.sensor_position;
            prod_reg     <= prod_next;
            cut_reg      <= cut_next;
            drive3_reg   <= drive3_next;
            dir3_reg     <= dir3_next;
            mag_reg      <= mag_next;
            div_reg      <= div_next;
            level_reg    <= level_next;
            drive4_reg   <= drive3_reg;
            dir4_reg     <= dir3_reg;
        end
    end

    assign rsp.valid         = valid_reg[3];
    assign rsp.direction     = dir4_reg;
    assign rsp.clock_divider = div_reg;
    assign rsp.pwm_level     = level_reg;
    assign rsp.drive         = drive4_reg;

    // A live drive always points the same way as the direction bit.
    `ASSERT_SAME(a_dir_matches_drive, rsp.valid && (rsp.drive != 16'sd0),
        rsp.direction == rsp.drive[15], "direction disagrees with nonzero drive")
    // With no drive the divider sits at the slow setting.
    `ASSERT_SAME(a_idle_divider, rsp.valid && (rsp.drive == 16'sd0),
        rsp.clock_divider == cfg.divider_slow, "zero drive must give the slow divider")
    // The level can only be on when there is drive.
    `ASSERT_SAME(a_level_needs_drive, rsp.valid && (rsp.pwm_level != 15'd0),
        rsp.drive != 16'sd0, "PWM level on without drive")
    // An item in the third stage reaches the output when the pipeline moves.
    `ASSERT_NEXT(a_stage_moves, valid_reg[2] && advance,
        valid_reg[3], "item lost between stage three and the output")

endmodule

>>> hw/rtl/ssd_cfg_regs.sv
module ssd_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data,
    output ssd_pkg::cfg_t                  cfg
);

    ssd_pkg::cfg_t cfg_reg;
    ssd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (ssd_pkg::cfg_idx_t'(cfg_index))
                ssd_pkg::CFG_GAIN:         cfg_next.gain         = cfg_data[23:0];
                ssd_pkg::CFG_DEADBAND:     cfg_next.deadband     = cfg_data[11:0];
                ssd_pkg::CFG_MIN_POSITION: cfg_next.min_position = cfg_data[11:0];
                ssd_pkg::CFG_MAX_POSITION: cfg_next.max_position = cfg_data[11:0];
                ssd_pkg::CFG_THRESHOLD:    cfg_next.threshold    = cfg_data[14:0];
                ssd_pkg::CFG_DIVIDER_SLOW: cfg_next.divider_slow = cfg_data[11:0];
                ssd_pkg::CFG_DIVIDER_FAST: cfg_next.divider_fast = cfg_data[11:0];
                ssd_pkg::CFG_PWM_WRAP:     cfg_next.pwm_wrap     = cfg_data[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain         <= ssd_pkg::GAIN_RESET;
            cfg_reg.deadband     <= ssd_pkg::DEADBAND_RESET;
            cfg_reg.min_position <= ssd_pkg::MIN_POSITION_RESET;
            cfg_reg.max_position <= ssd_pkg::MAX_POSITION_RESET;
            cfg_reg.threshold    <= ssd_pkg::THRESHOLD_RESET;
            cfg_reg.divider_slow <= ssd_pkg::DIVIDER_SLOW_RESET;
            cfg_reg.divider_fast <= ssd_pkg::DIVIDER_FAST_RESET;
            cfg_reg.pwm_wrap     <= ssd_pkg::PWM_WRAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
